### rtl/spf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speech pre-processing filter chain package
// Shared constants, coefficient formats and configuration register indexes.
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam int FRAC_BITS_DEF   = 20;
    localparam int STATE_WIDTH_DEF = 40;

    localparam int COEF_FRAC  = 20;
    localparam int COEF_WIDTH = 24;
    localparam int EMPH_WIDTH = 20;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int OUT_MAX    = 32767;

    // DC-blocking section, Q3.20.
    localparam logic signed [COEF_WIDTH-1:0] DC_B0 = -24'sd2097152;
    localparam logic signed [COEF_WIDTH-1:0] DC_B1 = 24'sd1048576;
    localparam logic signed [COEF_WIDTH-1:0] DC_A0 = -24'sd2092947;
    localparam logic signed [COEF_WIDTH-1:0] DC_A1 = 24'sd1044382;

    localparam logic [EMPH_WIDTH-1:0] EMPH_RESET = 20'd891290;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_RESP_NUM_1    = 3'd0,
        CFG_RESP_NUM_2    = 3'd1,
        CFG_RESP_DEN_1    = 3'd2,
        CFG_RESP_DEN_2    = 3'd3,
        CFG_EMPHASIS_COEF = 3'd4
    } t_cfg_idx;

endpackage

### rtl/spf_biquad.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad section
// Combinational second-order section: output and next memory values with
// rounded, saturated coefficient products.
// ----------------------------------------------------------------------------
module spf_biquad #(
    parameter int STATE_WIDTH = spf_pkg::STATE_WIDTH_DEF
) (
    input  logic signed [STATE_WIDTH-1:0]          i_x,
    input  logic signed [STATE_WIDTH-1:0]          i_m0,
    input  logic signed [STATE_WIDTH-1:0]          i_m1,
    input  logic signed [spf_pkg::COEF_WIDTH-1:0]  i_b0,
    input  logic signed [spf_pkg::COEF_WIDTH-1:0]  i_b1,
    input  logic signed [spf_pkg::COEF_WIDTH-1:0]  i_a0,
    input  logic signed [spf_pkg::COEF_WIDTH-1:0]  i_a1,
    output logic signed [STATE_WIDTH-1:0]          o_y,
    output logic signed [STATE_WIDTH-1:0]          o_m0_next,
    output logic signed [STATE_WIDTH-1:0]          o_m1_next
);

    localparam int W  = STATE_WIDTH;
    localparam int CW = spf_pkg::COEF_WIDTH;
    localparam int CF = spf_pkg::COEF_FRAC;
    localparam int PW = W + CW;
    localparam int DW = PW + 1;
    localparam int TW = DW - CF;

    localparam logic signed [DW-1:0] HALF = {{(DW-CF){1'b0}}, 1'b1, {(CF-1){1'b0}}};

    logic signed [W:0]    y_sum;
    logic signed [W-1:0]  y;
    logic signed [PW-1:0] p_b0;
    logic signed [PW-1:0] p_b1;
    logic signed [PW-1:0] p_a0;
    logic signed [PW-1:0] p_a1;
    logic signed [DW-1:0] d0;
    logic signed [DW-1:0] d1;
    logic signed [TW-1:0] s0;
    logic signed [TW-1:0] s1;
    logic signed [W-1:0]  t0;
    logic signed [W-1:0]  t1;
    logic signed [W:0]    m0_sum;

    always_comb begin
        y_sum = {i_x[W-1], i_x} + {i_m0[W-1], i_m0};
        if (y_sum[W] != y_sum[W-1]) begin
            y = {y_sum[W], {(W-1){~y_sum[W]}}};
        end else begin
            y = y_sum[W-1:0];
        end

        p_b0 = i_x * i_b0;
        p_b1 = i_x * i_b1;
        p_a0 = y * i_a0;
        p_a1 = y * i_a1;

        d0 = {p_b0[PW-1], p_b0} - {p_a0[PW-1], p_a0} + HALF;
        d1 = {p_b1[PW-1], p_b1} - {p_a1[PW-1], p_a1} + HALF;
        s0 = d0[DW-1:CF];
        s1 = d1[DW-1:CF];

        if (s0[TW-1:W-1] != {(TW-W+1){s0[TW-1]}}) begin
            t0 = {s0[TW-1], {(W-1){~s0[TW-1]}}};
        end else begin
            t0 = s0[W-1:0];
        end
        if (s1[TW-1:W-1] != {(TW-W+1){s1[TW-1]}}) begin
            t1 = {s1[TW-1], {(W-1){~s1[TW-1]}}};
        end else begin
            t1 = s1[W-1:0];
        end

        m0_sum = {i_m1[W-1], i_m1} + {t0[W-1], t0};
        if (m0_sum[W] != m0_sum[W-1]) begin
            o_m0_next = {m0_sum[W], {(W-1){~m0_sum[W]}}};
        end else begin
            o_m0_next = m0_sum[W-1:0];
        end
        o_m1_next = t1;
        o_y       = y;
    end

endmodule

### rtl/speech_preprocess_filter_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speech pre-processing filter chain
// DC-blocking biquad, configurable biquad and pre-emphasis on 16-bit samples,
// with rounding and saturation of the result.
// ----------------------------------------------------------------------------
// The block takes one sample item in every clock cycle unless the output is
// stalled. Each item is held in an input register, all three filter sections
// and the memory updates are evaluated combinationally from that register,
// and the rounded result is held in an output register. One item per cycle
// is sustained while the output is not stalled, because each section's
// memories are updated in the same cycle that the sample passes through it,
// ready for the next sample. Coefficient writes are taken in any cycle and
// must only be made while no item is in flight.
// ----------------------------------------------------------------------------
module speech_preprocess_filter_chain #(
    parameter int FRAC_BITS   = spf_pkg::FRAC_BITS_DEF,
    parameter int STATE_WIDTH = spf_pkg::STATE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [15:0]                 i_sample_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [15:0]                 o_sample_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [spf_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  logic [spf_pkg::COEF_WIDTH-1:0]     i_cfg_data
);

    localparam int W   = STATE_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int CW  = spf_pkg::COEF_WIDTH;
    localparam int EW  = spf_pkg::EMPH_WIDTH;
    localparam int CF  = spf_pkg::COEF_FRAC;
    localparam int XW  = ((16 + F > W) ? 16 + F : W) + 1;
    localparam int PW  = W + EW + 1;
    localparam int QW  = PW - CF;
    localparam int OW  = W + 1 - F;
    localparam int RW  = (OW > 17) ? OW : 17;

    localparam logic signed [PW-1:0] EHALF = {{(PW-CF){1'b0}}, 1'b1, {(CF-1){1'b0}}};
    localparam logic signed [W:0]    OHALF = {{(W+1-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
    localparam logic signed [RW-1:0] OMAX  = RW'(spf_pkg::OUT_MAX);
    localparam logic signed [RW-1:0] OMIN  = -OMAX;

    logic signed [CW-1:0] r_num_1;
    logic signed [CW-1:0] r_num_2;
    logic signed [CW-1:0] r_den_1;
    logic signed [CW-1:0] r_den_2;
    logic [EW-1:0]        r_emph;

    logic signed [15:0]   r_smp;
    logic                 r_smp_vld;
    logic                 r_out_vld;
    logic signed [15:0]   r_out;

    logic signed [W-1:0]  r_dc_m0;
    logic signed [W-1:0]  r_dc_m1;
    logic signed [W-1:0]  r_sh_m0;
    logic signed [W-1:0]  r_sh_m1;
    logic signed [W-1:0]  r_em_m;

    logic signed [W-1:0]  n_dc_m0;
    logic signed [W-1:0]  n_dc_m1;
    logic signed [W-1:0]  n_sh_m0;
    logic signed [W-1:0]  n_sh_m1;
    logic signed [W-1:0]  n_em_m;
    logic signed [15:0]   n_out;

    logic                 advance;
    logic signed [XW-1:0] x_ext;
    logic signed [W-1:0]  x_in;
    logic signed [W-1:0]  y_dc;
    logic signed [W-1:0]  y_sh;
    logic signed [W:0]    y_em_sum;
    logic signed [W-1:0]  y_em;
    logic signed [EW:0]   neg_coef;
    logic signed [PW-1:0] p_em;
    logic signed [QW-1:0] q_em;
    logic signed [W:0]    o_sum;
    logic signed [OW-1:0] o_shift;
    logic signed [RW-1:0] o_wide;

    assign advance     = r_smp_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_smp_vld || advance;
    assign o_out_valid = r_out_vld;
    assign o_sample_out = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_1 <= '0;
            r_num_2 <= '0;
            r_den_1 <= '0;
            r_den_2 <= '0;
            r_emph  <= spf_pkg::EMPH_RESET;
        end else if (i_cfg_valid) begin
            unique case (spf_pkg::t_cfg_idx'(i_cfg_index))
                spf_pkg::CFG_RESP_NUM_1:    r_num_1 <= i_cfg_data;
                spf_pkg::CFG_RESP_NUM_2:    r_num_2 <= i_cfg_data;
                spf_pkg::CFG_RESP_DEN_1:    r_den_1 <= i_cfg_data;
                spf_pkg::CFG_RESP_DEN_2:    r_den_2 <= i_cfg_data;
                spf_pkg::CFG_EMPHASIS_COEF: r_emph  <= i_cfg_data[EW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        x_ext = {{(XW-16-F){r_smp[15]}}, r_smp, {F{1'b0}}};
        if (x_ext[XW-1:W-1] != {(XW-W+1){x_ext[XW-1]}}) begin
            x_in = {x_ext[XW-1], {(W-1){~x_ext[XW-1]}}};
        end else begin
            x_in = x_ext[W-1:0];
        end
    end

    spf_biquad #(
        .STATE_WIDTH (W)
    ) u_dc (
        .i_x       (x_in),
        .i_m0      (r_dc_m0),
        .i_m1      (r_dc_m1),
        .i_b0      (spf_pkg::DC_B0),
        .i_b1      (spf_pkg::DC_B1),
        .i_a0      (spf_pkg::DC_A0),
        .i_a1      (spf_pkg::DC_A1),
        .o_y       (y_dc),
        .o_m0_next (n_dc_m0),
        .o_m1_next (n_dc_m1)
    );

    spf_biquad #(
        .STATE_WIDTH (W)
    ) u_shape (
        .i_x       (y_dc),
        .i_m0      (r_sh_m0),
        .i_m1      (r_sh_m1),
        .i_b0      (r_num_1),
        .i_b1      (r_num_2),
        .i_a0      (r_den_1),
        .i_a1      (r_den_2),
        .o_y       (y_sh),
        .o_m0_next (n_sh_m0),
        .o_m1_next (n_sh_m1)
    );

    always_comb begin
        y_em_sum = {y_sh[W-1], y_sh} + {r_em_m[W-1], r_em_m};
        if (y_em_sum[W] != y_em_sum[W-1]) begin
            y_em = {y_em_sum[W], {(W-1){~y_em_sum[W]}}};
        end else begin
            y_em = y_em_sum[W-1:0];
        end

        neg_coef = -$signed({1'b0, r_emph});
        p_em     = y_sh * neg_coef + EHALF;
        q_em     = p_em[PW-1:CF];
        if (q_em[QW-1:W-1] != {(QW-W+1){q_em[QW-1]}}) begin
            n_em_m = {q_em[QW-1], {(W-1){~q_em[QW-1]}}};
        end else begin
            n_em_m = q_em[W-1:0];
        end

        o_sum   = {y_em[W-1], y_em} + OHALF;
        o_shift = o_sum[W:F];
        o_wide  = RW'(o_shift);
        if (o_wide > OMAX) begin
            n_out = OMAX[15:0];
        end else if (o_wide < OMIN) begin
            n_out = OMIN[15:0];
        end else begin
            n_out = o_wide[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_dc_m0   <= '0;
            r_dc_m1   <= '0;
            r_sh_m0   <= '0;
            r_sh_m1   <= '0;
            r_em_m    <= '0;
        end else begin
            if (o_in_ready) begin
                r_smp_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_dc_m0   <= n_dc_m0;
                r_dc_m1   <= n_dc_m1;
                r_sh_m0   <= n_sh_m0;
                r_sh_m1   <= n_sh_m1;
                r_em_m    <= n_em_m;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_smp <= i_sample_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_smp_vld && r_out_vld && !i_out_ready) |=> (r_smp_vld && $stable(r_smp)))
        else $error("Held item lost while the output was stalled.");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_smp_vld)
        else $error("Accepted item did not reach the input register.");

    a_no_min_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sample_out != 16'sh8000))
        else $error("Result outside the saturation range.");

    a_state_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> ($stable(r_dc_m0) && $stable(r_sh_m0) && $stable(r_em_m)))
        else $error("Filter memory changed without an item.");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_smp_vld && !r_out_vld && r_dc_m0 == '0 && r_em_m == '0))
        else $error("Reset did not clear the filter state.");

endmodule
